// File: rtl/assert_macros.svh
// Assertion helpers shared by the solver RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MWAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define MWAS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/mwas_pkg.sv
// Shared types and constants for the max-weight assignment solver.
// No dependencies.
package mwas_pkg;

  localparam int MaxSizeDef    = 16;
  localparam int WeightBitsDef = 16;
  localparam int CfgBits       = 5;
  localparam int WeightInBits  = 16;
  localparam int IdxOutBits    = 4;
  localparam int TotalBits     = 20;

  localparam logic [CfgBits-1:0] SizeReset = 5'd16;

  typedef struct packed {
    logic [IdxOutBits-1:0] row;
    logic [IdxOutBits-1:0] col;
    logic [TotalBits-1:0]  total;
    logic                  last;
  } res_t;

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_MAX_RD = 25'h0000002,
    S_MAX_EV = 25'h0000004,
    S_AUG    = 25'h0000008,
    S_A1_RD  = 25'h0000010,
    S_A1_EV  = 25'h0000020,
    S_A2_RD  = 25'h0000040,
    S_A2_EV  = 25'h0000080,
    S_POP_RD = 25'h0000100,
    S_POP_EV = 25'h0000200,
    S_UNW_RD = 25'h0000400,
    S_UNW_EV = 25'h0000800,
    S_CHK    = 25'h0001000,
    S_G_ROW  = 25'h0002000,
    S_G_RD   = 25'h0004000,
    S_G_EV   = 25'h0008000,
    S_G_NXT  = 25'h0010000,
    S_M_ROW  = 25'h0020000,
    S_M_RD   = 25'h0040000,
    S_M_EV   = 25'h0080000,
    S_M_NXT  = 25'h0100000,
    S_STEP   = 25'h0200000,
    S_SUM_RD = 25'h0400000,
    S_SUM_EV = 25'h0800000,
    S_EMIT   = 25'h1000000
  } sol_state_e;

endpackage

// File: rtl/max_weight_assignment_solver_core.sv
// Top level of the max-weight assignment solver: config, loader, output register.
// Depends on mwas_pkg, mwas_solver and assert_macros.svh.
//
//  channel   direction  handshake                payload
//  in        input      in_valid_i / in_stall_o   weight_i, last_weight_i
//  out       output     out_valid_o / out_stall_i row_index_o, assigned_column_o,
//                                                 total_weight_o, last_row_o
//  cfg       input      cfg_we_i                  cfg_wdata_i (matrix size)
//
// Weights load at one per cycle while in_stall_o is low; the transaction carrying last_weight starts the solve.
// The solve walks the weight memory through its single read port, a read state then an evaluate
// state per entry visited, over several passes per label round.
// Results leave one per cycle through the output register while out_stall_i is low.
// Input stalls from the cycle after the last weight until the last result is handed off.
// Reset clears control state only; the weight memory needs no clearing pass.
`include "assert_macros.svh"

module max_weight_assignment_solver_core #(
  parameter int MaxSize    = mwas_pkg::MaxSizeDef,
  parameter int WeightBits = mwas_pkg::WeightBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mwas_pkg::CfgBits-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mwas_pkg::WeightInBits-1:0] weight_i,
  input  logic                              last_weight_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mwas_pkg::IdxOutBits-1:0]   row_index_o,
  output logic [mwas_pkg::IdxOutBits-1:0]   assigned_column_o,
  output logic [mwas_pkg::TotalBits-1:0]    total_weight_o,
  output logic                              last_row_o
);
  import mwas_pkg::*;

  localparam int NW    = $clog2(MaxSize + 1);
  localparam int Depth = MaxSize * MaxSize;
  localparam int AW    = $clog2(Depth);

  logic [CfgBits-1:0] matrix_size_q;
  logic [AW:0]        load_cnt_q;
  logic [NW-1:0]      size_eff;
  logic               in_take, ld_we, start, busy, res_vld, res_take, out_valid_q;
  res_t               res, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= SizeReset;
    end else if (cfg_we_i) begin
      matrix_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (matrix_size_q == '0) begin
      size_eff = NW'(1);
    end else if (int'(matrix_size_q) > MaxSize) begin
      size_eff = NW'(MaxSize);
    end else begin
      size_eff = NW'(matrix_size_q);
    end
  end

  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !in_stall_o;
  assign ld_we      = in_take && (load_cnt_q < (AW+1)'(Depth));
  assign start      = in_take && last_weight_i;

  // saturate the load count; drop weights past the store depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (start) begin
      load_cnt_q <= '0;
    end else if (ld_we) begin
      load_cnt_q <= load_cnt_q + (AW+1)'(1);
    end
  end

  mwas_solver #(
    .MaxSize   (MaxSize),
    .WeightBits(WeightBits)
  ) u_solver (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_we_i   (ld_we),
    .ld_addr_i (load_cnt_q[AW-1:0]),
    .ld_data_i (WeightBits'(weight_i)),
    .start_i   (start),
    .size_i    (size_eff),
    .busy_o    (busy),
    .res_vld_o (res_vld),
    .res_o     (res),
    .res_take_i(res_take)
  );

  assign res_take = res_vld && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign row_index_o       = out_q.row;
  assign assigned_column_o = out_q.col;
  assign total_weight_o    = out_q.total;
  assign last_row_o        = out_q.last;

  `MWAS_ASSERT(a_load_sat, load_cnt_q <= (AW+1)'(Depth), "load count past store depth")

endmodule

// File: rtl/mwas_solver.sv
// Sequencer of the solver: weight memory, dual labels, matching, DFS stack.
// Depends on mwas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mwas_solver #(
  parameter int MaxSize    = mwas_pkg::MaxSizeDef,
  parameter int WeightBits = mwas_pkg::WeightBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                ld_we_i,
  input  logic [$clog2(MaxSize*MaxSize)-1:0]  ld_addr_i,
  input  logic [WeightBits-1:0]               ld_data_i,
  input  logic                                start_i,
  input  logic [$clog2(MaxSize+1)-1:0]        size_i,
  output logic                                busy_o,
  output logic                                res_vld_o,
  output mwas_pkg::res_t                      res_o,
  input  logic                                res_take_i
);
  import mwas_pkg::*;

  localparam int IW    = $clog2(MaxSize);
  localparam int NW    = $clog2(MaxSize + 1);
  localparam int Depth = MaxSize * MaxSize;
  localparam int AW    = $clog2(Depth);
  localparam int LW    = WeightBits + IW + 3;

  sol_state_e state_q;

  logic [WeightBits-1:0] wmem [Depth];
  logic [WeightBits-1:0] rdata_q;
  logic [2*IW-1:0]       stk_mem [MaxSize];
  logic [2*IW-1:0]       stk_rd_q;

  logic [NW-1:0] n_q;
  logic [NW-1:0] sp_q;
  logic [IW-1:0] row_q, col_q, start_row_q;

  logic [MaxSize-1:0] owner_vld_q, row_match_q, row_reach_q, col_reach_q, seen_q;
  logic [IW-1:0]      owner_q [MaxSize];
  logic [IW-1:0]      asg_q   [MaxSize];
  logic signed [LW-1:0] rl_q [MaxSize];
  logic signed [LW-1:0] cl_q [MaxSize];

  logic                  grown_q, best_vld_q, step_vld_q;
  logic [WeightBits-1:0] best_w_q, max_q;
  logic [IW-1:0]         best_c_q;
  logic signed [LW:0]    step_q;
  logic [TotalBits-1:0]  total_q;

  logic [IW-1:0]      lastc, rd_row, fr_row, fr_col, nb_c;
  logic [AW-1:0]      rd_addr;
  logic [MaxSize-1:0] full;
  logic signed [LW:0] slack;
  logic               tight, col_last, row_last, cand, nb_vld, push;
  logic [WeightBits-1:0] newmax;

  always_comb begin
    for (int i = 0; i < MaxSize; i++) begin
      full[i] = (NW'(i) < n_q);
    end
  end

  assign lastc    = IW'(n_q - NW'(1));
  assign col_last = (col_q == lastc);
  assign row_last = (row_q == lastc);
  assign rd_row   = (state_q == S_SUM_RD) ? owner_q[col_q] : row_q;
  assign rd_addr  = AW'(rd_row) * AW'(n_q) + AW'(col_q);
  assign {fr_row, fr_col} = stk_rd_q;

  assign slack = (LW+1)'(rl_q[row_q]) + (LW+1)'(cl_q[col_q])
               - $signed((LW+1)'(rdata_q));
  assign tight = (slack == '0);

  assign cand   = tight && !owner_vld_q[col_q] && (!best_vld_q || rdata_q > best_w_q);
  assign nb_vld = best_vld_q || cand;
  assign nb_c   = cand ? col_q : best_c_q;
  assign newmax = (col_q == '0 || rdata_q > max_q) ? rdata_q : max_q;
  assign push   = (state_q == S_A2_EV) && tight && !seen_q[col_q] && owner_vld_q[col_q];

  // weight store: one write port for loading, one registered read port
  always_ff @(posedge clk_i) begin
    if (ld_we_i) begin
      wmem[ld_addr_i] <= ld_data_i;
    end
    rdata_q <= wmem[rd_addr];
  end

  // DFS stack of (row, column) frames
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_mem[IW'(sp_q)] <= {row_q, col_q};
    end
    stk_rd_q <= stk_mem[IW'(sp_q - NW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      sp_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      start_row_q <= '0;
      owner_vld_q <= '0;
      row_match_q <= '0;
      row_reach_q <= '0;
      col_reach_q <= '0;
      seen_q      <= '0;
      grown_q     <= 1'b0;
      best_vld_q  <= 1'b0;
      step_vld_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            n_q         <= size_i;
            row_q       <= '0;
            col_q       <= '0;
            owner_vld_q <= '0;
            row_match_q <= '0;
            for (int i = 0; i < MaxSize; i++) begin
              cl_q[i] <= '0;
            end
            state_q <= S_MAX_RD;
          end
        end
        S_MAX_RD: state_q <= S_MAX_EV;
        S_MAX_EV: begin
          if (col_last) begin
            rl_q[row_q] <= LW'(newmax);
            col_q <= '0;
            if (row_last) begin
              start_row_q <= '0;
              state_q     <= S_AUG;
            end else begin
              row_q   <= row_q + IW'(1);
              state_q <= S_MAX_RD;
            end
          end else begin
            max_q   <= newmax;
            col_q   <= col_q + IW'(1);
            state_q <= S_MAX_RD;
          end
        end
        S_AUG: begin
          if (row_match_q[start_row_q]) begin
            if (start_row_q == lastc) begin
              state_q <= S_CHK;
            end else begin
              start_row_q <= start_row_q + IW'(1);
            end
          end else begin
            row_q      <= start_row_q;
            col_q      <= '0;
            seen_q     <= '0;
            sp_q       <= '0;
            best_vld_q <= 1'b0;
            state_q    <= S_A1_RD;
          end
        end
        S_A1_RD: state_q <= S_A1_EV;
        S_A1_EV: begin
          if (col_last) begin
            if (nb_vld) begin
              owner_q[nb_c]     <= row_q;
              owner_vld_q[nb_c] <= 1'b1;
              if (sp_q == '0) begin
                row_match_q[start_row_q] <= 1'b1;
                state_q <= S_AUG;
              end else begin
                state_q <= S_UNW_RD;
              end
            end else begin
              col_q   <= '0;
              state_q <= S_A2_RD;
            end
          end else begin
            best_vld_q <= nb_vld;
            best_c_q   <= nb_c;
            if (cand) begin
              best_w_q <= rdata_q;
            end
            col_q   <= col_q + IW'(1);
            state_q <= S_A1_RD;
          end
        end
        S_A2_RD: state_q <= S_A2_EV;
        S_A2_EV: begin
          if (push) begin
            // descend into the row that owns this tight column
            seen_q[col_q] <= 1'b1;
            sp_q          <= sp_q + NW'(1);
            row_q         <= owner_q[col_q];
            col_q         <= '0;
            best_vld_q    <= 1'b0;
            state_q       <= S_A1_RD;
          end else if (col_last) begin
            if (sp_q == '0) begin
              if (start_row_q == lastc) begin
                state_q <= S_CHK;
              end else begin
                start_row_q <= start_row_q + IW'(1);
                state_q     <= S_AUG;
              end
            end else begin
              state_q <= S_POP_RD;
            end
          end else begin
            col_q   <= col_q + IW'(1);
            state_q <= S_A2_RD;
          end
        end
        S_POP_RD: state_q <= S_POP_EV;
        S_POP_EV: begin
          sp_q <= sp_q - NW'(1);
          if (fr_col == lastc) begin
            if (sp_q == NW'(1)) begin
              if (start_row_q == lastc) begin
                state_q <= S_CHK;
              end else begin
                start_row_q <= start_row_q + IW'(1);
                state_q     <= S_AUG;
              end
            end else begin
              state_q <= S_POP_RD;
            end
          end else begin
            row_q   <= fr_row;
            col_q   <= fr_col + IW'(1);
            state_q <= S_A2_RD;
          end
        end
        S_UNW_RD: state_q <= S_UNW_EV;
        S_UNW_EV: begin
          // flip the path edge back toward the start row
          owner_q[fr_col] <= fr_row;
          sp_q <= sp_q - NW'(1);
          if (sp_q == NW'(1)) begin
            row_match_q[start_row_q] <= 1'b1;
            state_q <= S_AUG;
          end else begin
            state_q <= S_UNW_RD;
          end
        end
        S_CHK: begin
          if (row_match_q == full) begin
            col_q   <= '0;
            total_q <= '0;
            for (int i = 0; i < MaxSize; i++) begin
              asg_q[i] <= '0;
            end
            state_q <= S_SUM_RD;
          end else begin
            row_reach_q <= full & ~row_match_q;
            col_reach_q <= '0;
            row_q       <= '0;
            grown_q     <= 1'b0;
            state_q     <= S_G_ROW;
          end
        end
        S_G_ROW: begin
          col_q   <= '0;
          state_q <= row_reach_q[row_q] ? S_G_RD : S_G_NXT;
        end
        S_G_RD: state_q <= S_G_EV;
        S_G_EV: begin
          if (tight && !col_reach_q[col_q]) begin
            col_reach_q[col_q] <= 1'b1;
            grown_q            <= 1'b1;
            if (owner_vld_q[col_q]) begin
              row_reach_q[owner_q[col_q]] <= 1'b1;
            end
          end
          if (col_last) begin
            state_q <= S_G_NXT;
          end else begin
            col_q   <= col_q + IW'(1);
            state_q <= S_G_RD;
          end
        end
        S_G_NXT: begin
          if (row_last) begin
            row_q <= '0;
            if (grown_q) begin
              grown_q <= 1'b0;
              state_q <= S_G_ROW;
            end else begin
              step_vld_q <= 1'b0;
              state_q    <= S_M_ROW;
            end
          end else begin
            row_q   <= row_q + IW'(1);
            state_q <= S_G_ROW;
          end
        end
        S_M_ROW: begin
          col_q   <= '0;
          state_q <= row_reach_q[row_q] ? S_M_RD : S_M_NXT;
        end
        S_M_RD: state_q <= S_M_EV;
        S_M_EV: begin
          if (!col_reach_q[col_q] && (!step_vld_q || slack < step_q)) begin
            step_q     <= slack;
            step_vld_q <= 1'b1;
          end
          if (col_last) begin
            state_q <= S_M_NXT;
          end else begin
            col_q   <= col_q + IW'(1);
            state_q <= S_M_RD;
          end
        end
        S_M_NXT: begin
          if (row_last) begin
            state_q <= S_STEP;
          end else begin
            row_q   <= row_q + IW'(1);
            state_q <= S_M_ROW;
          end
        end
        S_STEP: begin
          if (!step_vld_q || step_q <= '0) begin
            col_q   <= '0;
            total_q <= '0;
            for (int i = 0; i < MaxSize; i++) begin
              asg_q[i] <= '0;
            end
            state_q <= S_SUM_RD;
          end else begin
            for (int i = 0; i < MaxSize; i++) begin
              if (row_reach_q[i]) begin
                rl_q[i] <= LW'((LW+1)'(rl_q[i]) - step_q);
              end
              if (col_reach_q[i]) begin
                cl_q[i] <= LW'((LW+1)'(cl_q[i]) + step_q);
              end
            end
            start_row_q <= '0;
            state_q     <= S_AUG;
          end
        end
        S_SUM_RD: begin
          if (owner_vld_q[col_q]) begin
            state_q <= S_SUM_EV;
          end else if (col_last) begin
            row_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            col_q <= col_q + IW'(1);
          end
        end
        S_SUM_EV: begin
          total_q <= total_q + TotalBits'(rdata_q);
          asg_q[owner_q[col_q]] <= col_q;
          if (col_last) begin
            row_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            col_q   <= col_q + IW'(1);
            state_q <= S_SUM_RD;
          end
        end
        S_EMIT: begin
          if (res_take_i) begin
            if (row_last) begin
              state_q <= S_IDLE;
            end else begin
              row_q <= row_q + IW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign res_vld_o = (state_q == S_EMIT);
  assign res_o.row   = IdxOutBits'(row_q);
  assign res_o.col   = IdxOutBits'(asg_q[row_q]);
  assign res_o.total = total_q;
  assign res_o.last  = row_last;

  `MWAS_ASSERT(a_sp_bound, sp_q <= n_q, "DFS stack deeper than matrix size")
  `MWAS_ASSERT_NEVER(a_match_range, (row_match_q & ~full) != '0 && state_q != S_IDLE, "matched row beyond matrix size")
  `MWAS_ASSERT(a_owner_range, (state_q == S_A2_EV && owner_vld_q[col_q]) |-> (NW'(owner_q[col_q]) < n_q), "column owner outside matrix")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for max_weight_assignment_solver_core.
// Depends on mwas_pkg and the solver RTL; predicts every assignment with its own solver.
`timescale 1ns / 1ps

module testbench;
  import mwas_pkg::*;

  localparam int Dim       = 16;
  localparam int Depth     = Dim * Dim;
  localparam int NoOwner   = Dim;
  localparam longint Huge  = 64'h7FFFFFFFFFFFFFFF;
  localparam int IdleLimit = 2000000;
  localparam int HoldLen   = 2000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgBits-1:0]      cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [WeightInBits-1:0] weight_i = '0;
  logic                    last_weight_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IdxOutBits-1:0]   row_index_o;
  logic [IdxOutBits-1:0]   assigned_column_o;
  logic [TotalBits-1:0]    total_weight_o;
  logic                    last_row_o;

  max_weight_assignment_solver_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .weight_i, .last_weight_i, .out_valid_o, .out_stall_i, .row_index_o,
    .assigned_column_o, .total_weight_o, .last_row_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]    wmem [Depth];
  longint         slack [Depth];
  longint         row_lab [Dim];
  longint         col_lab [Dim];
  int             owner [Dim];
  logic [15:0]    row_hit, col_hit, aug_seen;
  logic [4:0]     size_reg = SizeReset;
  int             n_act = 1;
  int             load_cnt = 0;
  int             written_hi = 0;
  res_t           assign_q [$];

  int  fails = 0;
  bit  quiet = 1'b0;
  int  hold_req = 0;
  int  rand_items = 0;

  function automatic bit tight(int r, int c);
    return slack[r * n_act + c] == 0;
  endfunction

  function automatic logic [15:0] matched_rows();
    logic [15:0] m;
    m = '0;
    for (int c = 0; c < n_act; c++) if (owner[c] != NoOwner) m[owner[c]] = 1'b1;
    return m;
  endfunction

  function automatic bit grow_path(int r);
    int best;
    longint best_w;
    best = -1;
    best_w = 0;
    for (int c = 0; c < n_act; c++) begin
      if (tight(r, c) && owner[c] == NoOwner) begin
        if (best < 0 || longint'(wmem[r * n_act + c]) > best_w) begin
          best = c;
          best_w = wmem[r * n_act + c];
        end
      end
    end
    if (best >= 0) begin
      owner[best] = r;
      return 1'b1;
    end
    for (int c = 0; c < n_act; c++) begin
      if (tight(r, c) && !aug_seen[c] && owner[c] != NoOwner) begin
        aug_seen[c] = 1'b1;
        if (grow_path(owner[c])) begin
          owner[c] = r;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void solve_assignment();
    logic [15:0] full, matched;
    longint      mx, step;
    bit          grown, dummy;
    full = (n_act == 16) ? 16'hFFFF : 16'((1 << n_act) - 1);
    for (int r = 0; r < n_act; r++) begin
      mx = wmem[r * n_act];
      for (int c = 1; c < n_act; c++) if (longint'(wmem[r * n_act + c]) > mx) mx = wmem[r * n_act + c];
      row_lab[r] = mx;
    end
    for (int c = 0; c < Dim; c++) begin
      col_lab[c] = 0;
      owner[c] = NoOwner;
    end
    forever begin
      step = Huge;
      for (int r = 0; r < n_act; r++)
        for (int c = 0; c < n_act; c++)
          slack[r * n_act + c] = row_lab[r] + col_lab[c] - longint'(wmem[r * n_act + c]);
      for (int r = 0; r < n_act; r++) begin
        matched = matched_rows();
        if (!matched[r]) begin
          aug_seen = '0;
          dummy = grow_path(r);
        end
      end
      matched = matched_rows();
      if (matched == full) break;
      row_hit = full & ~matched;
      col_hit = '0;
      do begin
        grown = 1'b0;
        for (int r = 0; r < n_act; r++) begin
          if (!row_hit[r]) continue;
          for (int c = 0; c < n_act; c++) begin
            if (tight(r, c) && !col_hit[c]) begin
              col_hit[c] = 1'b1;
              grown = 1'b1;
              if (owner[c] != NoOwner) row_hit[owner[c]] = 1'b1;
            end
          end
        end
      end while (grown);
      for (int r = 0; r < n_act; r++) begin
        if (!row_hit[r]) continue;
        for (int c = 0; c < n_act; c++)
          if (!col_hit[c] && slack[r * n_act + c] < step) step = slack[r * n_act + c];
      end
      if (step == Huge || step <= 0) break;
      for (int r = 0; r < n_act; r++) if (row_hit[r]) row_lab[r] -= step;
      for (int c = 0; c < n_act; c++) if (col_hit[c]) col_lab[c] += step;
    end
  endfunction

  // Advance the predictor by one accepted weight.
  function automatic void predict_weight(logic [15:0] w, logic last);
    int   cols [Dim];
    longint sum;
    res_t e;
    if (load_cnt < Depth) begin
      wmem[load_cnt] = w;
      load_cnt++;
      if (load_cnt > written_hi) written_hi = load_cnt;
    end
    if (!last) return;
    n_act = (size_reg < 1) ? 1 : (size_reg > Dim) ? Dim : int'(size_reg);
    solve_assignment();
    load_cnt = 0;
    sum = 0;
    for (int r = 0; r < Dim; r++) cols[r] = 0;
    for (int c = 0; c < n_act; c++) begin
      if (owner[c] < n_act) begin
        cols[owner[c]] = c;
        sum += wmem[owner[c] * n_act + c];
      end
    end
    for (int r = 0; r < n_act; r++) begin
      e.row = r[3:0];
      e.col = cols[r][3:0];
      e.total = sum[19:0];
      e.last = (r + 1 == n_act);
      assign_q.push_back(e);
    end
  endfunction

  // Receiver: random stall, long hold-off on request, result check, watchdog.
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cnt = 0;
  res_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (assign_q.size() == 0) begin
          $error("result row %0d arrived with no expectation", row_index_o);
          fails++;
        end else begin
          exp_r = assign_q.pop_front();
          if (row_index_o !== exp_r.row) begin
            $error("row_index: expected %0d, got %0d", exp_r.row, row_index_o);
            fails++;
          end
          if (assigned_column_o !== exp_r.col) begin
            $error("assigned_column: expected %0d, got %0d", exp_r.col, assigned_column_o);
            fails++;
          end
          if (total_weight_o !== exp_r.total) begin
            $error("total_weight: expected %0d, got %0d", exp_r.total, total_weight_o);
            fails++;
          end
          if (last_row_o !== exp_r.last) begin
            $error("last_row: expected %0d, got %0d", exp_r.last, last_row_o);
            fails++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldLen;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 17);
      end
    end
  end

  task automatic send_weight(logic [15:0] w, logic last);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    weight_i <= w;
    last_weight_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_weight(w, last);
  endtask

  // Hold until every expected transaction has arrived, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (assign_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_size(logic [4:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v;
  endtask

  function automatic logic [15:0] pick_weight(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(3));
      2: return 16'd500;
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic send_matrix(int n, int mode, int count);
    for (int k = 0; k < count; k++) send_weight(pick_weight(mode), k == count - 1);
  endtask

  task automatic test_single_entry();
    set_size(5'd1);
    send_weight(16'hFFFF, 1'b1);
    set_size(5'd0);
    send_weight(16'h0000, 1'b1);
  endtask

  task automatic test_small_cases();
    logic [15:0] diag [4] = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
    logic [15:0] anti [4] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
    set_size(5'd2);
    for (int k = 0; k < 4; k++) send_weight(diag[k], k == 3);
    for (int k = 0; k < 4; k++) send_weight(anti[k], k == 3);
    // all ties: lowest column wins
    set_size(5'd3);
    send_matrix(3, 2, 9);
    // short load keeps the rest of the stored matrix
    set_size(5'd2);
    send_weight(16'h1234, 1'b0);
    send_weight(16'h00FF, 1'b1);
  endtask

  task automatic test_random_matrices();
    int n, mode, count;
    quiet = 1'b0;
    while (rand_items < 150) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
      mode = $urandom_range(3);
      count = n * n;
      // short load only over entries that already hold a weight
      if ($urandom_range(7) == 0 && n > 1 && n * n <= written_hi)
        count = $urandom_range(1, n * n - 1);
      if (rand_items > 60 && rand_items < 110) quiet = 1'b1;
      else quiet = 1'b0;
      set_size(5'(n));
      send_matrix(n, mode, count);
      rand_items += count;
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_holdoff();
    set_size(5'd4);
    hold_req++;
    send_matrix(4, 0, 16);
    send_matrix(4, 3, 16);
    send_matrix(4, 1, 16);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_entry();
    test_small_cases();
    test_output_holdoff();
    test_random_matrices();
    drain();
    repeat (50) @(posedge clk_i);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mwas_pkg.sv
rtl/mwas_solver.sv
rtl/max_weight_assignment_solver_core.sv
sim/testbench.sv
